FILE: design/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// Used by every module of the block but pse_ram; no dependencies of its own.
`default_nettype none

package pse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_STAR  = 8'h2A;
   localparam logic [7:0] SYM_SLASH = 8'h2F;
   localparam logic [7:0] SYM_ZERO  = 8'd48;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_UNDER   = 2'd1;
   localparam logic [1:0] ERR_OVER    = 2'd2;
   localparam logic [1:0] ERR_DIVZERO = 2'd3;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_kind_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [1:0]               error_code;
   } rsp_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [DATA_W-1:0] imm;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: design/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/pse_div.sv
// Radix-2 restoring signed divider, truncating toward zero, one bit per cycle.
// Depends on pse_pkg.
`default_nettype none

module pse_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pse_pkg::div_req_type div_req,
   output pse_pkg::div_rsp_type      div_rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [pse_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            neg_ff, neg_in;
   logic [pse_pkg::DATA_W-1:0]      dvs_ff, dvs_in;
   logic [pse_pkg::DATA_W-1:0]      rem_ff, rem_in;
   logic [pse_pkg::DATA_W-1:0]      quo_ff, quo_in;
   logic [pse_pkg::DATA_W-1:0]      mag_a, mag_b;
   logic [pse_pkg::DATA_W:0]        rem_sh, diff;

   assign mag_a  = div_req.dividend[pse_pkg::DATA_W-1] ? (~div_req.dividend + 1'b1)
                                                       : div_req.dividend;
   assign mag_b  = div_req.divisor[pse_pkg::DATA_W-1] ? (~div_req.divisor + 1'b1)
                                                      : div_req.divisor;
   assign rem_sh = {rem_ff, quo_ff[pse_pkg::DATA_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = pse_pkg::DIV_CNT_W'(pse_pkg::DATA_W);
         neg_in  = div_req.dividend[pse_pkg::DATA_W-1] ^ div_req.divisor[pse_pkg::DATA_W-1];
         dvs_in  = mag_b;
         rem_in  = '0;
         quo_in  = mag_a;
      end else if (busy_ff) begin
         if (!diff[pse_pkg::DATA_W]) begin
            rem_in = diff[pse_pkg::DATA_W-1:0];
            quo_in = {quo_ff[pse_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[pse_pkg::DATA_W-1:0];
            quo_in = {quo_ff[pse_pkg::DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pse_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

`default_nettype wire

FILE: design/pse_front.sv
// Front end: accepts characters, decodes operator or operand, and queues commands.
// Depends on pse_pkg.
`default_nettype none

module pse_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pse_pkg::req_type req_data,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output pse_pkg::cmd_type      cmd
);

   pse_pkg::cmd_type              queue_ff [pse_pkg::QUEUE_DEPTH];
   pse_pkg::cmd_type              cmd_in;
   logic [pse_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pse_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pse_pkg::QFILL_W-1:0]   fill_ff, fill_in;
   logic                          push, pop;

   always_comb begin
      case (req_data.symbol)
         pse_pkg::SYM_PLUS:  cmd_in.kind = pse_pkg::OP_ADD;
         pse_pkg::SYM_MINUS: cmd_in.kind = pse_pkg::OP_SUB;
         pse_pkg::SYM_STAR:  cmd_in.kind = pse_pkg::OP_MUL;
         pse_pkg::SYM_SLASH: cmd_in.kind = pse_pkg::OP_DIV;
         default:            cmd_in.kind = pse_pkg::OP_PUSH;
      endcase
      cmd_in.imm  = pse_pkg::DATA_W'(req_data.symbol) - pse_pkg::DATA_W'(pse_pkg::SYM_ZERO);
      cmd_in.last = req_data.last;
   end

   assign req_ready = (fill_ff != pse_pkg::QFILL_W'(pse_pkg::QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pse_pkg::QPTR_W'(pse_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pse_pkg::QPTR_W'(pse_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/pse_back.sv
// Back end: sequences stack pops, arithmetic and pushes, and emits final results.
// Depends on pse_pkg and pse_ram; drives the divider through structs.
`default_nettype none

module pse_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   output logic                      cmd_ready,
   input  wire pse_pkg::cmd_type     cmd,
   output pse_pkg::div_req_type      div_req,
   input  wire pse_pkg::div_rsp_type div_rsp,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pse_pkg::rsp_type          rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_R,
      S_POP_L,
      S_EXEC,
      S_DIV_WAIT,
      S_PUSH,
      S_FINAL,
      S_EMIT
   } state_type;

   state_type                     state_ff, state_in;
   logic [pse_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [1:0]                    err_ff, err_in;
   pse_pkg::op_kind_type          kind_ff, kind_in;
   logic                          last_ff, last_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic [pse_pkg::DATA_W-1:0]    right_ff, right_in;
   logic [pse_pkg::DATA_W-1:0]    result_ff, result_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pse_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                          wr_en, rd_en;
   logic [pse_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
   logic [pse_pkg::DATA_W-1:0]    rd_data;
   logic [pse_pkg::COUNT_W-1:0]   count_dec;
   logic [pse_pkg::DATA_W-1:0]    popped;
   logic                          emit_go;

   pse_ram #(
      .WIDTH(pse_pkg::DATA_W),
      .DEPTH(pse_pkg::STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(result_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign count_dec = count_ff - 1'b1;
   assign rd_addr   = count_dec[pse_pkg::ADDR_W-1:0];
   assign wr_addr   = count_ff[pse_pkg::ADDR_W-1:0];
   assign popped    = rd_pend_ff ? rd_data : '0;
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      rd_pend_in   = rd_pend_ff;
      right_in     = right_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = popped;
      div_req.divisor  = right_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               kind_in   = cmd.kind;
               last_in   = cmd.last;
               result_in = cmd.imm;
               state_in  = (cmd.kind == pse_pkg::OP_PUSH) ? S_PUSH : S_POP_R;
            end
         end
         S_POP_R, S_POP_L, S_FINAL: begin
            if (state_ff == S_POP_L) begin
               right_in = popped;
            end
            if (count_ff == '0) begin
               rd_pend_in = 1'b0;
               if (err_ff == pse_pkg::ERR_NONE) begin
                  err_in = pse_pkg::ERR_UNDER;
               end
            end else begin
               rd_pend_in = 1'b1;
               rd_en      = 1'b1;
               count_in   = count_dec;
            end
            case (state_ff)
               S_POP_R: state_in = S_POP_L;
               S_POP_L: state_in = S_EXEC;
               default: state_in = S_EMIT;
            endcase
         end
         S_EXEC: begin
            state_in = S_PUSH;
            case (kind_ff)
               pse_pkg::OP_ADD: result_in = popped + right_ff;
               pse_pkg::OP_SUB: result_in = popped - right_ff;
               pse_pkg::OP_MUL: result_in = pse_pkg::DATA_W'(popped * right_ff);
               default: begin
                  if (right_ff == '0) begin
                     result_in = '0;
                     if (err_ff == pse_pkg::ERR_NONE) begin
                        err_in = pse_pkg::ERR_DIVZERO;
                     end
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = S_DIV_WAIT;
                  end
               end
            endcase
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               result_in = div_rsp.quotient;
               state_in  = S_PUSH;
            end
         end
         S_PUSH: begin
            if (count_ff >= pse_pkg::COUNT_W'(pse_pkg::STACK_DEPTH)) begin
               if (err_ff == pse_pkg::ERR_NONE) begin
                  err_in = pse_pkg::ERR_OVER;
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
            state_in = last_ff ? S_FINAL : S_IDLE;
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.value      = popped;
               rsp_data_in.error_code = err_ff;
               count_in               = '0;
               err_in                 = pse_pkg::ERR_NONE;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= pse_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      right_ff    <= right_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pse_pkg::COUNT_W'(pse_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (rsp_valid_ff && count_ff == '0 && err_ff == pse_pkg::ERR_NONE))
      else $error("result emitted without clearing the stack");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != pse_pkg::ERR_NONE && state_ff != S_EMIT) |=> (err_ff == $past(err_ff)))
      else $error("sticky error changed within an expression");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> (state_ff == S_DIV_WAIT && $past(div_req.divisor) != '0))
      else $error("divider started on a zero divisor");
`endif

endmodule

`default_nettype wire

FILE: design/postfix_stack_evaluator.sv
// Postfix expression evaluator: takes one character per request, returns one
// response with the final value and error code on the character marked last.
// In the back end a push passes S_IDLE and S_PUSH; + - * pop the right and
// left operands, execute and push, and / also waits on the 32-step radix-2
// divider unless the divisor is zero; the final pop and emit follow, plus any
// wait on rsp_ready. Stack reads go through the single read port of the stack
// memory, one operand per cycle. A two-entry command queue lets requests be
// taken while the back end works. The stack memory needs no clearing pass.
// Depends on pse_pkg, pse_front, pse_back, pse_div and pse_ram.
`default_nettype none

module postfix_stack_evaluator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pse_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pse_pkg::rsp_type      rsp_data
);

   logic                 cmd_valid;
   logic                 cmd_ready;
   pse_pkg::cmd_type     cmd;
   pse_pkg::div_req_type div_req;
   pse_pkg::div_rsp_type div_rsp;

   pse_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .cmd_valid(cmd_valid),
      .cmd_ready(cmd_ready),
      .cmd      (cmd)
   );

   pse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd_ready(cmd_ready),
      .cmd      (cmd),
      .div_req  (div_req),
      .div_rsp  (div_rsp),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   pse_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

endmodule

`default_nettype wire
